[hw/rtl/cgc_pkg.sv]
package cgc_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int NORMAL_FRAC_BITS = 12;
  localparam int NUM_REGS         = 6;
  localparam int MID_DEPTH        = 2;
  localparam int OUT_DEPTH        = 4;
  localparam int SUM_W            = 50;

  localparam logic [2:0] REG_COV_00 = 3'd0;
  localparam logic [2:0] REG_COV_10 = 3'd1;
  localparam logic [2:0] REG_COV_11 = 3'd2;
  localparam logic [2:0] REG_COV_20 = 3'd3;
  localparam logic [2:0] REG_COV_21 = 3'd4;
  localparam logic [2:0] REG_COV_22 = 3'd5;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [15:0] normal_0;
    logic signed [15:0] normal_1;
    logic signed [15:0] normal_2;
  } normal_t;

  typedef struct packed {
    logic signed [31:0] sample_0;
    logic signed [31:0] sample_1;
    logic signed [31:0] sample_2;
    logic               degenerate;
  } sample_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               degen;
    logic signed [31:0] l00;
    logic signed [31:0] l10;
    logic signed [31:0] l11;
    logic signed [31:0] l20;
    logic signed [31:0] l21;
    logic signed [31:0] l22;
  } factor_t;

  function automatic logic signed [31:0] sat_floor(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] sh;
    sh = s >>> NORMAL_FRAC_BITS;
    if (sh > SUM_W'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (sh < SUM_W'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return sh[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

endpackage

[hw/rtl/correlated_gaussian_from_cholesky.sv]
// An accepted item waits in the input queue until the result queue has room, then passes through the product registers.
// One item per cycle is sustained while the result queue is popped; the product stage is a two-deep pipeline.
// After reset, or a write to a covariance register, the factor is rebuilt by a
// shared square-root and divide sequencer, with full held high.
// Reset is synchronous and active high; it restores the identity covariance.
module correlated_gaussian_from_cholesky import cgc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  normal_t     normals,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output sample_t     sample,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int MCW = $clog2(MID_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  cfg_t           cfg;
  factor_t        factor;
  logic [MCW-1:0] mid_count;
  logic [OCW-1:0] out_count;
  normal_t        mid_data;
  logic           accept;
  logic           issue;
  logic           mac_valid;
  sample_t        mac_out;
  logic [1:0]     inflight;
  logic           v_a;
  logic           v_b;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  cgc_factor u_factor (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .factor (factor)
  );

  assign full   = !factor.valid || (mid_count == MCW'(MID_DEPTH));
  assign accept = push && !full;

  cgc_fifo #(.WIDTH($bits(normal_t)), .DEPTH(MID_DEPTH)) u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (normals),
    .pop   (issue),
    .rdata (mid_data),
    .count (mid_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
    end else begin
      v_a <= issue;
      v_b <= v_a;
    end
  end

  assign inflight = {1'b0, v_a} + {1'b0, v_b};
  assign issue    = (mid_count != '0) &&
                    (4'(out_count) + 4'(inflight) < 4'(OUT_DEPTH));

  cgc_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (issue),
    .z         (mid_data),
    .f         (factor),
    .out_valid (mac_valid),
    .out       (mac_out)
  );

  cgc_fifo #(.WIDTH($bits(sample_t)), .DEPTH(OUT_DEPTH)) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (mac_valid),
    .wdata (mac_out),
    .pop   (pop && !empty),
    .rdata (sample),
    .count (out_count)
  );

  assign empty = (out_count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mac_valid |-> (out_count != OCW'(OUT_DEPTH)) || (pop && !empty))
    else $error("result queue overflow");

  a_credit: assert property (@(posedge clk) disable iff (rst)
    (4'(out_count) + 4'(inflight)) <= 4'(OUT_DEPTH))
    else $error("credit count exceeded");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index < 3'(NUM_REGS)) |=> full)
    else $error("input open after covariance write");

  a_mac_sync: assert property (@(posedge clk) disable iff (rst)
    mac_valid == v_b)
    else $error("product pipeline out of step");

endmodule

[hw/rtl/cgc_fifo.sv]
module cgc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= wdata;
        wr_ptr      <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rdata = mem[rd_ptr];

endmodule

[hw/rtl/cgc_factor.sv]
module cgc_factor import cgc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  output factor_t factor
);

  logic signed [31:0] cov [NUM_REGS];
  logic signed [31:0] l [NUM_REGS];
  logic               degen;
  logic               valid;
  logic               busy;
  logic [3:0]         step;
  logic [2:0]         tgt;
  logic               run_sqrt;
  logic               run_div;
  logic [6:0]         cnt;
  logic [63:0]        sq_op;
  logic [63:0]        sq_res;
  logic [63:0]        sq_one;
  logic [32:0]        dv_rem;
  logic [63:0]        dv_q;
  logic               dv_neg;
  logic [63:0]        acc;
  logic signed [63:0] prod;

  logic signed [31:0] vd;
  logic signed [65:0] diff;
  logic [63:0]        diag_mag;
  logic signed [65:0] num;
  logic [63:0]        num_mag;
  logic [31:0]        divisor;
  logic [63:0]        trial;
  logic               sq_ge;
  logic [32:0]        shifted;
  logic               dv_ge;
  logic signed [31:0] sq_sat;
  logic signed [31:0] dv_sat;
  logic               cfg_hit;

  assign cfg_hit = cfg.we && (cfg.index < 3'(NUM_REGS));

  always_comb begin
    case (step)
      4'd0:    vd = cov[REG_COV_00];
      4'd4:    vd = cov[REG_COV_11];
      default: vd = cov[REG_COV_22];
    endcase
    diff     = 66'(signed'({vd, {FRAC_BITS{1'b0}}})) - signed'({2'b00, acc});
    diag_mag = diff[65] ? 64'(-diff) : diff[63:0];
    case (step)
      4'd1:    num = 66'(signed'({cov[REG_COV_10], {FRAC_BITS{1'b0}}}));
      4'd2:    num = 66'(signed'({cov[REG_COV_20], {FRAC_BITS{1'b0}}}));
      default: num = 66'(signed'({cov[REG_COV_21], {FRAC_BITS{1'b0}}})) - 66'(prod);
    endcase
    num_mag = num[65] ? 64'(-num) : num[63:0];
    divisor = (step == 4'd6) ? l[2] : l[0];
    trial   = sq_res + sq_one;
    sq_ge   = sq_op >= trial;
    shifted = {dv_rem[31:0], dv_q[63]};
    dv_ge   = shifted >= {1'b0, divisor};
    sq_sat  = (sq_res > 64'h7fff_ffff) ? SAT_MAX : sq_res[31:0];
    if (dv_neg) begin
      dv_sat = (dv_q > 64'h8000_0000) ? SAT_MIN : 32'(-dv_q);
    end else begin
      dv_sat = (dv_q > 64'h7fff_ffff) ? SAT_MAX : dv_q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cov[0]   <= ONE_Q16;
      cov[1]   <= '0;
      cov[2]   <= ONE_Q16;
      cov[3]   <= '0;
      cov[4]   <= '0;
      cov[5]   <= ONE_Q16;
      valid    <= 1'b0;
      busy     <= 1'b0;
      run_sqrt <= 1'b0;
      run_div  <= 1'b0;
      degen    <= 1'b0;
    end else if (cfg_hit) begin
      cov[cfg.index] <= cfg.data;
      valid          <= 1'b0;
      busy           <= 1'b0;
      run_sqrt       <= 1'b0;
      run_div        <= 1'b0;
    end else if (!valid && !busy) begin
      busy  <= 1'b1;
      step  <= 4'd0;
      degen <= 1'b0;
      acc   <= '0;
    end else if (busy) begin
      if (run_sqrt) begin
        if (sq_one == '0) begin
          l[tgt]   <= sq_sat;
          run_sqrt <= 1'b0;
          step     <= step + 4'd1;
        end else begin
          if (sq_ge) begin
            sq_op  <= sq_op - trial;
            sq_res <= (sq_res >> 1) + sq_one;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_one <= sq_one >> 2;
        end
      end else if (run_div) begin
        if (cnt == '0) begin
          l[tgt]  <= dv_sat;
          run_div <= 1'b0;
          step    <= step + 4'd1;
        end else begin
          dv_rem <= dv_ge ? shifted - {1'b0, divisor} : shifted;
          dv_q   <= {dv_q[62:0], dv_ge};
          cnt    <= cnt - 7'd1;
        end
      end else begin
        case (step)
          4'd0, 4'd4, 4'd9: begin
            sq_op    <= diag_mag;
            sq_res   <= '0;
            sq_one   <= 64'h4000_0000_0000_0000;
            run_sqrt <= 1'b1;
            tgt      <= (step == 4'd0) ? 3'd0 : ((step == 4'd4) ? 3'd2 : 3'd5);
          end
          4'd1, 4'd2, 4'd6: begin
            if (divisor == '0) begin
              l[(step == 4'd1) ? 3'd1 : ((step == 4'd2) ? 3'd3 : 3'd4)] <= '0;
              degen <= 1'b1;
              step  <= step + 4'd1;
            end else begin
              dv_rem  <= '0;
              dv_q    <= num_mag;
              dv_neg  <= num[65];
              cnt     <= 7'd64;
              run_div <= 1'b1;
              tgt     <= (step == 4'd1) ? 3'd1 : ((step == 4'd2) ? 3'd3 : 3'd4);
            end
          end
          4'd3: begin
            acc  <= mag32(l[1]) * mag32(l[1]);
            step <= step + 4'd1;
          end
          4'd5: begin
            prod <= l[3] * l[1];
            step <= step + 4'd1;
          end
          4'd7: begin
            acc  <= mag32(l[3]) * mag32(l[3]);
            step <= step + 4'd1;
          end
          4'd8: begin
            acc  <= acc + mag32(l[4]) * mag32(l[4]);
            step <= step + 4'd1;
          end
          default: begin
            busy  <= 1'b0;
            valid <= 1'b1;
          end
        endcase
      end
    end
  end

  assign factor.valid = valid;
  assign factor.degen = degen;
  assign factor.l00   = l[0];
  assign factor.l10   = l[1];
  assign factor.l11   = l[2];
  assign factor.l20   = l[3];
  assign factor.l21   = l[4];
  assign factor.l22   = l[5];

endmodule

[hw/rtl/cgc_mac.sv]
module cgc_mac import cgc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  normal_t z,
  input  factor_t f,
  output logic    out_valid,
  output sample_t out
);

  logic               v1;
  logic               v2;
  logic signed [47:0] p0;
  logic signed [47:0] p1;
  logic signed [47:0] p2;
  logic signed [47:0] p3;
  logic signed [47:0] p4;
  logic signed [47:0] p5;
  logic               d1;
  sample_t            res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
    p0  <= f.l00 * z.normal_0;
    p1  <= f.l10 * z.normal_0;
    p2  <= f.l11 * z.normal_1;
    p3  <= f.l20 * z.normal_0;
    p4  <= f.l21 * z.normal_1;
    p5  <= f.l22 * z.normal_2;
    d1  <= f.degen;
    res.sample_0   <= sat_floor(SUM_W'(p0));
    res.sample_1   <= sat_floor(SUM_W'(p1) + SUM_W'(p2));
    res.sample_2   <= sat_floor(SUM_W'(p3) + SUM_W'(p4) + SUM_W'(p5));
    res.degenerate <= d1;
  end

  assign out_valid = v2;
  assign out       = res;

endmodule
